FILE: rtl/core/peak_auto_gain_with_fade_ramp_macros.svh
// Assertion macros shared by the gain control block.
// Each macro assumes a clock named clk and a synchronous reset named rst.
`ifndef PEAK_AUTO_GAIN_WITH_FADE_RAMP_MACROS_SVH
`define PEAK_AUTO_GAIN_WITH_FADE_RAMP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside reset
`define PAGC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pagc check failed");
// Check that a condition in one cycle implies another in the next
`define PAGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pagc sequence check failed");
`else
`define PAGC_ASSERT(label, prop)
`define PAGC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/pagc_pkg.sv
// ----------------------------------------------------------------------------
// pagc_pkg
// Types and fixed constants of the peak-normalising gain control block.
// ----------------------------------------------------------------------------
`default_nettype none

package pagc_pkg;

  // Unity gain in Q8.16
  localparam logic [23:0] GAIN_ONE = 24'd65536;

  // Divider operand widths
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;

  // Sample format codes
  localparam logic [1:0] FMT_S8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FORMAT   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_MAX_GAIN = 2'd2;
  localparam logic [1:0] CFG_SCALING  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN_DIV,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_MEAN_DIV,
    ST_FADE_MUL,
    ST_FRAMES_DIV,
    ST_STEP_DIV,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_EMIT
  } state_t;

  typedef struct packed {
    logic              go;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/pagc_ram.sv
// ----------------------------------------------------------------------------
// pagc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pagc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pagc_div.sv
// ----------------------------------------------------------------------------
// pagc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "peak_auto_gain_with_fade_ramp_macros.svh"

module pagc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pagc_pkg::div_req_t req,
  output pagc_pkg::div_rsp_t      rsp
);

  localparam int NW = pagc_pkg::DIV_NW;
  localparam int DW = pagc_pkg::DIV_DW;
  localparam int CNW = $clog2(NW);

  logic           running;
  logic           done;
  logic [CNW-1:0] cnt;
  logic [NW-1:0]  n;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  den_r;
  logic [DW:0]    rem_sh;
  logic           qbit;
  logic [DW-1:0]  rem_next;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh   = {rem, n[NW-1]};
    qbit     = (rem_sh >= {1'b0, den_r});
    rem_next = qbit ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
  end

  // Iterate over the dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        cnt     <= '0;
        n       <= req.num;
        rem     <= '0;
        den_r   <= req.den;
      end else if (running) begin
        rem <= rem_next;
        n   <= {n[NW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = n;
  assign rsp.rem  = rem;

  `PAGC_ASSERT(a_go_when_free, req.go |-> !running)
  `PAGC_ASSERT(a_done_stopped, done |-> !running)

endmodule

`default_nettype wire

FILE: rtl/core/peak_auto_gain_with_fade_ramp.sv
// ----------------------------------------------------------------------------
// peak_auto_gain_with_fade_ramp
// Buffers interleaved samples, derives a peak-normalising gain averaged over
// recent buffers and replays the buffer through a per-frame fade ramp.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  config    in         cfg_we                cfg_index, cfg_data
//  sample    in         start & !busy         sample_in, buffer_end,
//                                             fade_start, fade_end
//  result    out        out_valid (strobe)    sample_out, out_last
//
// A sample that does not end the buffer is taken without raising busy.
// A buffer end keeps busy high through three shared divider runs (headroom
// gain, frame count, ramp step) and the history read, history write and fade
// products, then through a store read, multiply and saturate per replayed
// sample; a history depth that is not a power of two adds a divider run
// for the mean. busy falls in the cycle that carries the last result.
// Results cannot be stalled; each is valid for one cycle only.
// After rst the block is ready at once: no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "peak_auto_gain_with_fade_ramp_macros.svh"

module peak_auto_gain_with_fade_ramp #(
  parameter int BUFFER_SAMPLES = 64,
  parameter int HISTORY_DEPTH  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] sample_in,
  input  wire logic               buffer_end,
  input  wire logic [16:0]        fade_start,
  input  wire logic [16:0]        fade_end,
  output logic                    out_valid,
  output logic signed [31:0]      sample_out,
  output logic                    out_last
);

  localparam int AW = (BUFFER_SAMPLES > 1) ? $clog2(BUFFER_SAMPLES) : 1;
  localparam int CW = $clog2(BUFFER_SAMPLES + 1);
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SW = 24 + $clog2(HISTORY_DEPTH + 1);
  localparam int NW = pagc_pkg::DIV_NW;
  localparam int DW = pagc_pkg::DIV_DW;
  localparam int HSH = $clog2(HISTORY_DEPTH);
  localparam bit HIST_POW2 = ((HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0);

  // Configuration registers
  logic [1:0]  sample_format;
  logic [3:0]  frame_chans;
  logic [23:0] max_auto_gain;
  logic        scaling_enabled;

  // Sequencer and buffer state
  pagc_pkg::state_t state, state_next;
  logic [CW-1:0]      fill_count;
  logic [CW-1:0]      count;
  logic signed [31:0] peak_low;
  logic signed [31:0] peak_high;
  logic [16:0]        fade_start_r;
  logic [16:0]        fade_end_r;

  // Gain state
  logic [HISTORY_DEPTH-1:0] hist_valid;
  logic [HW-1:0]            history_slot;
  logic [SW-1:0]            hist_sum;
  logic [23:0]              previous_gain;
  logic [23:0]              possible;
  logic [23:0]              wanted;
  logic [23:0]              last_gain;

  // Ramp state
  logic [24:0]        ramp_start;
  logic [24:0]        ramp_end;
  logic [6:0]         frames;
  logic [25:0]        step_q;
  logic [6:0]         step_r;
  logic [25:0]        ramp_q;
  logic [6:0]         ramp_r;
  logic [25:0]        scale;
  logic [CW-1:0]      k;
  logic [2:0]         chan;
  logic signed [58:0] prod;
  logic signed [31:0] raw;

  // Memory and divider ports
  logic        store_we;
  logic [31:0] store_rdata;
  logic [23:0] hist_rdata;
  logic        hist_we;
  pagc_pkg::div_req_t div_req;
  pagc_pkg::div_rsp_t div_rsp;

  // Combinational helpers
  logic signed [31:0] s_ext;
  logic signed [31:0] fmt_hi;
  logic signed [31:0] fmt_lo;
  logic signed [31:0] pk_lo_new;
  logic signed [31:0] pk_hi_new;
  logic [31:0]        mag_lo;
  logic [31:0]        mag_hi;
  logic [31:0]        mag;
  logic               accept;
  logic               buf_done;
  logic               do_meas;
  logic [3:0]         ch;
  logic [SW-1:0]      hist_old;
  logic [SW-1:0]      sum_next;
  logic [NW-1:0]      quot_lo;
  logic [23:0]        gain_clamped;
  logic               mean_ready;
  logic [23:0]        mean_val;
  logic [23:0]        wanted_next;
  logic [25:0]        ramp_diff;
  logic               ramp_down;
  logic [40:0]        st_prod;
  logic [40:0]        en_prod;
  logic [7:0]         frames_num;
  logic signed [42:0] q_trunc;
  logic signed [31:0] q_sat;
  logic               is_last;
  logic               frame_wrap;
  logic [7:0]         ramp_r_sum;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format   <= pagc_pkg::FMT_S16;
      frame_chans     <= 4'd2;
      max_auto_gain   <= pagc_pkg::GAIN_ONE;
      scaling_enabled <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pagc_pkg::CFG_FORMAT:   sample_format   <= cfg_data[1:0];
        pagc_pkg::CFG_CHANNELS: frame_chans     <= cfg_data[3:0];
        pagc_pkg::CFG_MAX_GAIN: max_auto_gain   <= cfg_data;
        pagc_pkg::CFG_SCALING:  scaling_enabled <= cfg_data[0];
      endcase
    end
  end

  // Format decode: sign extension and full-scale limits
  always_comb begin
    unique case (sample_format)
      pagc_pkg::FMT_S8: begin
        s_ext  = {{24{sample_in[7]}}, sample_in[7:0]};
        fmt_hi = 32'sd127;
        fmt_lo = -32'sd128;
      end
      pagc_pkg::FMT_S16: begin
        s_ext  = {{16{sample_in[15]}}, sample_in[15:0]};
        fmt_hi = 32'sd32767;
        fmt_lo = -32'sd32768;
      end
      default: begin
        s_ext  = sample_in;
        fmt_hi = 32'sh7fffffff;
        fmt_lo = 32'sh80000000;
      end
    endcase
  end

  // Peak tracking, restarted on the first sample of a buffer
  always_comb begin
    pk_lo_new = (fill_count == '0) ? fmt_hi : peak_low;
    pk_hi_new = (fill_count == '0) ? fmt_lo : peak_high;
    if (s_ext < pk_lo_new) pk_lo_new = s_ext;
    if (s_ext > pk_hi_new) pk_hi_new = s_ext;
    mag_lo  = pk_lo_new[31] ? 32'(-pk_lo_new) : 32'(pk_lo_new);
    mag_hi  = pk_hi_new[31] ? 32'(-pk_hi_new) : 32'(pk_hi_new);
    mag     = (mag_lo > mag_hi) ? mag_lo : mag_hi;
    do_meas = (max_auto_gain > pagc_pkg::GAIN_ONE) && (mag != '0);
  end

  assign accept   = start && (state == pagc_pkg::ST_IDLE);
  assign buf_done = buffer_end || (fill_count == CW'(BUFFER_SAMPLES - 1));
  assign busy     = (state != pagc_pkg::ST_IDLE);

  // Channel count held between one and eight
  always_comb begin
    if (frame_chans == 4'd0) ch = 4'd1;
    else if (frame_chans > 4'd8) ch = 4'd8;
    else ch = frame_chans;
  end

  // Gain arithmetic
  always_comb begin
    quot_lo = (div_rsp.quot < NW'(pagc_pkg::GAIN_ONE)) ? NW'(pagc_pkg::GAIN_ONE)
                                                         : div_rsp.quot;
    gain_clamped = (quot_lo > NW'(max_auto_gain)) ? max_auto_gain : quot_lo[23:0];
    hist_old   = hist_valid[history_slot] ? SW'(hist_rdata) : SW'(pagc_pkg::GAIN_ONE);
    sum_next   = hist_sum - hist_old + SW'(possible);
    // Ring mean: a shift for a power-of-two depth, else the shared divider
    mean_ready = HIST_POW2 ? (state == pagc_pkg::ST_HIST_WR)
                           : ((state == pagc_pkg::ST_MEAN_DIV) && div_rsp.done);
    mean_val   = HIST_POW2 ? 24'(sum_next >> HSH) : div_rsp.quot[23:0];
    wanted_next = (mean_val < possible) ? mean_val : possible;
    st_prod    = fade_start_r * last_gain;
    en_prod    = fade_end_r * wanted;
    frames_num = 8'(count) + 8'(ch) - 8'd1;
    ramp_down  = (ramp_end < ramp_start);
    ramp_diff  = ramp_down ? 26'(ramp_start - ramp_end) : 26'(ramp_end - ramp_start);
  end

  // Output arithmetic: truncate toward zero, then saturate
  always_comb begin
    q_trunc = prod[58] ? 43'((prod + 59'sd65535) >>> 16) : 43'(prod >>> 16);
    if (q_trunc > 43'(fmt_hi)) q_sat = fmt_hi;
    else if (q_trunc < 43'(fmt_lo)) q_sat = fmt_lo;
    else q_sat = q_trunc[31:0];
    is_last    = (CW'(k + 1'b1) == count);
    frame_wrap = ({1'b0, chan} + 4'd1 == ch);
    ramp_r_sum = {1'b0, ramp_r} + {1'b0, step_r};
  end

  // Sequencer: next state and divider requests
  always_comb begin
    state_next  = state;
    div_req.go  = 1'b0;
    div_req.num = '0;
    div_req.den = '0;
    store_we    = 1'b0;
    hist_we     = 1'b0;
    unique case (state)
      pagc_pkg::ST_IDLE: begin
        if (accept) begin
          store_we = 1'b1;
          if (buf_done) begin
            div_req.go  = 1'b1;
            div_req.num = do_meas ? NW'({fmt_hi, 16'h0000}) : NW'(pagc_pkg::GAIN_ONE);
            div_req.den = do_meas ? mag : DW'(1);
            state_next  = pagc_pkg::ST_GAIN_DIV;
          end
        end
      end
      pagc_pkg::ST_GAIN_DIV: begin
        if (div_rsp.done) state_next = pagc_pkg::ST_HIST_RD;
      end
      pagc_pkg::ST_HIST_RD: begin
        state_next = pagc_pkg::ST_HIST_WR;
      end
      pagc_pkg::ST_HIST_WR: begin
        hist_we = 1'b1;
        if (HIST_POW2) begin
          state_next = pagc_pkg::ST_FADE_MUL;
        end else begin
          div_req.go  = 1'b1;
          div_req.num = NW'(sum_next);
          div_req.den = DW'(HISTORY_DEPTH);
          state_next  = pagc_pkg::ST_MEAN_DIV;
        end
      end
      pagc_pkg::ST_MEAN_DIV: begin
        if (div_rsp.done) state_next = pagc_pkg::ST_FADE_MUL;
      end
      pagc_pkg::ST_FADE_MUL: begin
        div_req.go  = 1'b1;
        div_req.num = NW'(frames_num);
        div_req.den = DW'(ch);
        state_next  = pagc_pkg::ST_FRAMES_DIV;
      end
      pagc_pkg::ST_FRAMES_DIV: begin
        if (div_rsp.done) begin
          div_req.go  = 1'b1;
          div_req.num = NW'(ramp_diff);
          div_req.den = div_rsp.quot[DW-1:0];
          state_next  = pagc_pkg::ST_STEP_DIV;
        end
      end
      pagc_pkg::ST_STEP_DIV: begin
        if (div_rsp.done) state_next = pagc_pkg::ST_OUT_RD;
      end
      pagc_pkg::ST_OUT_RD: begin
        state_next = pagc_pkg::ST_OUT_MUL;
      end
      pagc_pkg::ST_OUT_MUL: begin
        state_next = pagc_pkg::ST_OUT_EMIT;
      end
      pagc_pkg::ST_OUT_EMIT: begin
        state_next = is_last ? pagc_pkg::ST_IDLE : pagc_pkg::ST_OUT_RD;
      end
      default: state_next = pagc_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pagc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: fill count, history ring, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      peak_low      <= 32'sd32767;
      peak_high     <= -32'sd32768;
      hist_valid    <= '0;
      history_slot  <= '0;
      hist_sum      <= SW'(HISTORY_DEPTH * 65536);
      previous_gain <= pagc_pkg::GAIN_ONE;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (accept) begin
        peak_low   <= pk_lo_new;
        peak_high  <= pk_hi_new;
        fill_count <= buf_done ? '0 : CW'(fill_count + 1'b1);
      end
      if (state == pagc_pkg::ST_HIST_WR) begin
        hist_valid[history_slot] <= 1'b1;
        hist_sum                 <= sum_next;
        history_slot <= (history_slot == HW'(HISTORY_DEPTH - 1)) ? '0
                                                                 : HW'(history_slot + 1'b1);
      end
      if (mean_ready) begin
        previous_gain <= wanted_next;
      end
      if (state == pagc_pkg::ST_OUT_EMIT) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      pagc_pkg::ST_IDLE: begin
        if (accept && buf_done) begin
          count        <= CW'(fill_count + 1'b1);
          fade_start_r <= fade_start;
          fade_end_r   <= fade_end;
        end
      end
      pagc_pkg::ST_GAIN_DIV: begin
        if (div_rsp.done) possible <= gain_clamped;
      end
      pagc_pkg::ST_HIST_WR, pagc_pkg::ST_MEAN_DIV: begin
        if (mean_ready) begin
          wanted    <= wanted_next;
          last_gain <= (previous_gain < possible) ? previous_gain : possible;
        end
      end
      pagc_pkg::ST_FADE_MUL: begin
        ramp_start <= st_prod[40:16];
        ramp_end   <= en_prod[40:16];
      end
      pagc_pkg::ST_FRAMES_DIV: begin
        if (div_rsp.done) frames <= div_rsp.quot[6:0];
      end
      pagc_pkg::ST_STEP_DIV: begin
        if (div_rsp.done) begin
          step_q <= div_rsp.quot[25:0];
          step_r <= div_rsp.rem[6:0];
          ramp_q <= '0;
          ramp_r <= '0;
          k      <= '0;
          chan   <= '0;
        end
      end
      pagc_pkg::ST_OUT_RD: begin
        scale <= ramp_down ? 26'(ramp_start - ramp_q) : 26'(ramp_start + ramp_q);
      end
      pagc_pkg::ST_OUT_MUL: begin
        prod <= $signed(store_rdata) * $signed({1'b0, scale});
        raw  <= $signed(store_rdata);
      end
      pagc_pkg::ST_OUT_EMIT: begin
        sample_out <= scaling_enabled ? q_sat : raw;
        out_last   <= is_last;
        k          <= CW'(k + 1'b1);
        // Advance the ramp once per frame
        if (frame_wrap) begin
          chan <= '0;
          if (ramp_r_sum >= {1'b0, frames}) begin
            ramp_r <= 7'(ramp_r_sum - {1'b0, frames});
            ramp_q <= ramp_q + step_q + 26'd1;
          end else begin
            ramp_r <= ramp_r_sum[6:0];
            ramp_q <= ramp_q + step_q;
          end
        end else begin
          chan <= chan + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  pagc_ram #(
    .WIDTH (32),
    .DEPTH (BUFFER_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (s_ext),
    .raddr (k[AW-1:0]),
    .rdata (store_rdata)
  );

  pagc_ram #(
    .WIDTH (24),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (history_slot),
    .wdata (possible),
    .raddr (history_slot),
    .rdata (hist_rdata)
  );

  pagc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `PAGC_ASSERT_NEXT(a_end_goes_busy, accept && buf_done, busy)
  `PAGC_ASSERT(a_strobe_from_run, out_valid |-> $past(busy))
  `PAGC_ASSERT_NEXT(a_last_ends_burst, out_valid && out_last, !out_valid)

endmodule

`default_nettype wire

FILE: dv/peak_auto_gain_with_fade_ramp_tb.sv
// ----------------------------------------------------------------------------
// peak_auto_gain_with_fade_ramp_tb
// Drives buffers of samples through the gain block under several register
// settings and idle patterns, predicts each replayed buffer and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peak_auto_gain_with_fade_ramp_tb;

  localparam int STORE_DEPTH = 64;
  localparam int HIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } replay_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pagc_pkg::CFG_FORMAT;
  logic [23:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] sample_in = '0;
  logic buffer_end = 1'b0;
  logic [16:0] fade_start = '0;
  logic [16:0] fade_end = '0;
  logic out_valid;
  logic signed [31:0] sample_out;
  logic out_last;

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;

  // Report one mismatch and count it
  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Gain predictor and store of replayed samples still awaited
  class gain_scoreboard;
    logic [1:0] fmt;
    logic [3:0] chans;
    logic [23:0] max_gain;
    logic scale_on;
    longint store[STORE_DEPTH];
    int fill;
    longint pk_lo, pk_hi;
    longint history[HIST_DEPTH];
    int slot;
    longint prev_gain;
    replay_t awaited[$];

    function new();
      fmt = pagc_pkg::FMT_S16; chans = 4'd2; max_gain = pagc_pkg::GAIN_ONE;
      scale_on = 1'b1;
      fill = 0; slot = 0; prev_gain = pagc_pkg::GAIN_ONE; pk_lo = 0; pk_hi = 0;
      foreach (history[i]) history[i] = pagc_pkg::GAIN_ONE;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        pagc_pkg::CFG_FORMAT:   fmt = val[1:0];
        pagc_pkg::CFG_CHANNELS: chans = val[3:0];
        pagc_pkg::CFG_MAX_GAIN: max_gain = val;
        default:                scale_on = val[0];
      endcase
    endfunction

    function void note_sample(logic [31:0] raw, logic fin, logic [16:0] fs, logic [16:0] fe);
      int bits, count, ch, frames;
      longint s, lo, hi, mag, possible, sum, wanted, lastg, st, en, v, scale;
      bits = (fmt == pagc_pkg::FMT_S8) ? 8 : (fmt == pagc_pkg::FMT_S16) ? 16 : 32;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -(64'sd1 <<< (bits - 1));
      s = (bits == 8) ? longint'($signed(raw[7:0])) :
          (bits == 16) ? longint'($signed(raw[15:0])) : longint'($signed(raw));
      if (fill == 0) begin
        pk_lo = hi; pk_hi = lo;
      end
      store[fill] = s;
      if (s < pk_lo) pk_lo = s;
      if (s > pk_hi) pk_hi = s;
      fill++;
      if (!fin && fill < STORE_DEPTH) return;
      count = fill;
      fill = 0;
      // Headroom gain, held between unity and the limit
      possible = pagc_pkg::GAIN_ONE;
      if (max_gain > pagc_pkg::GAIN_ONE) begin
        mag = (pk_lo < 0 ? -pk_lo : pk_lo);
        if ((pk_hi < 0 ? -pk_hi : pk_hi) > mag) mag = (pk_hi < 0 ? -pk_hi : pk_hi);
        if (mag != 0) possible = (hi * pagc_pkg::GAIN_ONE) / mag;
      end
      if (possible < pagc_pkg::GAIN_ONE) possible = pagc_pkg::GAIN_ONE;
      if (possible > max_gain) possible = max_gain;
      history[slot] = possible;
      slot = (slot + 1) % HIST_DEPTH;
      sum = 0;
      foreach (history[i]) sum += history[i];
      wanted = sum / HIST_DEPTH;
      if (wanted > possible) wanted = possible;
      lastg = (prev_gain < possible) ? prev_gain : possible;
      prev_gain = wanted;
      st = (longint'(fs) * lastg) >>> 16;
      en = (longint'(fe) * wanted) >>> 16;
      ch = (chans == 0) ? 1 : (chans > 8) ? 8 : chans;
      frames = (count + ch - 1) / ch;
      // Replay through the per-frame ramp
      for (int k = 0; k < count; k++) begin
        v = store[k];
        if (scale_on) begin
          scale = st + ((en - st) * (k / ch)) / frames;
          v = (v * scale) / 65536;
          if (v > hi) v = hi;
          if (v < lo) v = lo;
        end
        awaited.push_back('{sample: v[31:0], last: (k + 1 == count)});
      end
    endfunction

    task check_result(logic [31:0] got, logic got_last);
      replay_t exp_r;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      exp_r = awaited.pop_front();
      if (got !== exp_r.sample)
        report_mismatch($sformatf("sample_out %h, want %h", got, exp_r.sample));
      if (got_last !== exp_r.last)
        report_mismatch($sformatf("out_last %b, want %b", got_last, exp_r.last));
    endtask
  endclass

  gain_scoreboard board = new();

  peak_auto_gain_with_fade_ramp DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .sample_in(sample_in), .buffer_end(buffer_end),
    .fade_start(fade_start), .fade_end(fade_end), .out_valid(out_valid),
    .sample_out(sample_out), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // Check every strobed result; watch the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid) board.check_result(sample_out, out_last);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("peak_auto_gain_with_fade_ramp regression: fail");
      $finish;
    end
  end

  // Write one register while the block is idle, then drop cfg_we before returning
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop start, wait for all replays, then let the sequencer settle
  task automatic drain();
    start <= 1'b0;
    while (board.awaited.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Transfer one sample, with random idle cycles ahead of it; start stays
  // high after the transfer until the next idle cycle or drain drops it
  task automatic send_sample(input logic [31:0] s, input logic fin,
                             input logic [16:0] fs, input logic [16:0] fe);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; sample_in <= s; buffer_end <= fin;
    fade_start <= fs; fade_end <= fe;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_sample(s, fin, fs, fe);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(255) - 128;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_fade();
    case ($urandom_range(4))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1ffff;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // Send one buffer of random content
  task automatic send_buffer(input int len);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(), i == len - 1, rand_fade(), rand_fade());
  endtask

  // Pick a random setting of every register
  task automatic random_setting();
    write_reg(pagc_pkg::CFG_FORMAT, 24'($urandom_range(3)));
    write_reg(pagc_pkg::CFG_CHANNELS, 24'($urandom_range(15)));
    case ($urandom_range(3))
      0: write_reg(pagc_pkg::CFG_MAX_GAIN, 24'hffffff);
      1: write_reg(pagc_pkg::CFG_MAX_GAIN, 24'($urandom_range(65536)));
      default: write_reg(pagc_pkg::CFG_MAX_GAIN, 24'($urandom));
    endcase
    write_reg(pagc_pkg::CFG_SCALING, 24'($urandom_range(99) < 80));
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset setting, extremes, full store, silence
    send_sample(32'h00007fff, 1'b0, 17'd65536, 17'd65536);
    send_sample(32'hffff8000, 1'b1, 17'd65536, 17'd65536);
    drain();
    write_reg(pagc_pkg::CFG_FORMAT, 24'(pagc_pkg::FMT_S8));
    write_reg(pagc_pkg::CFG_CHANNELS, 24'd3);
    write_reg(pagc_pkg::CFG_MAX_GAIN, 24'hffffff);
    write_reg(pagc_pkg::CFG_SCALING, 24'd1);
    send_sample(32'h00000010, 1'b0, 17'd0, 17'h1ffff);
    send_sample(32'hffffff81, 1'b0, 17'd0, 17'h1ffff);
    send_sample(32'h00000000, 1'b0, 17'd0, 17'h1ffff);
    send_sample(32'h0000007f, 1'b1, 17'd0, 17'h1ffff);
    send_sample(32'h00000000, 1'b1, 17'd65536, 17'd65536);
    drain();
    write_reg(pagc_pkg::CFG_FORMAT, 24'd3);
    write_reg(pagc_pkg::CFG_CHANNELS, 24'd0);
    write_reg(pagc_pkg::CFG_MAX_GAIN, 24'd0);
    send_sample(32'h7fffffff, 1'b1, 17'd65536, 17'd65536);
    drain();
    write_reg(pagc_pkg::CFG_FORMAT, 24'(pagc_pkg::FMT_S32));
    write_reg(pagc_pkg::CFG_CHANNELS, 24'd15);
    write_reg(pagc_pkg::CFG_MAX_GAIN, 24'd200000);
    write_reg(pagc_pkg::CFG_SCALING, 24'd0);
    send_sample(32'h80000000, 1'b0, 17'd65536, 17'd0);
    send_sample(32'h00001234, 1'b1, 17'd65536, 17'd0);
    drain();
    write_reg(pagc_pkg::CFG_SCALING, 24'd1);
    send_buffer(STORE_DEPTH);
    drain();

    // Random phases: no idling alternates with sender idling at a high or lower rate
    sent = 0;
    for (int ph = 0; sent < 400; ph++) begin
      send_idle_pct = (ph % 4 == 1) ? 73 : (ph % 4 == 3) ? 34 : 0;
      random_setting();
      for (int b = 0; b < 4; b++) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(STORE_DEPTH + 4, 1)
                                       : $urandom_range(8, 1);
        send_buffer(len);
        sent += len;
      end
      drain();
    end

    drain();
    if (error_count == 0 && board.awaited.size() == 0)
      $display("peak_auto_gain_with_fade_ramp regression: pass");
    else
      $display("peak_auto_gain_with_fade_ramp regression: fail");
    $finish;
  end
endmodule
